[sv/rpi_pkg.sv]
package rpi_pkg;

   typedef logic signed [31:0] fix_type;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_PARALLEL = 2'd1,
      ST_BEHIND   = 2'd2,
      ST_SAT      = 2'd3
   } status_type;

   // magnitude width of the dot products and quotient width
   localparam int MAG_W = 48;
   localparam int Q_W   = 31;
   localparam logic [Q_W-1:0] T_MAX = '1;

   localparam logic [2:0] REG_NORMAL_X  = 3'd0;
   localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
   localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
   localparam logic [2:0] REG_OFFSET    = 3'd3;
   localparam logic [2:0] REG_TOLERANCE = 3'd4;

   typedef struct packed {
      logic                 valid;
      status_type           kind;     // ST_HIT: go on, else early result
      logic                 ovf;
      logic [MAG_W-1:0]     rem;
      logic [Q_W-1:0]       xlow;
      logic [Q_W-1:0]       quo;
      logic [MAG_W-1:0]     dvs;
      fix_type [2:0]        org;
      fix_type [2:0]        dir;
   } div_stage_type;

endpackage

[sv/ray_plane_intersect.sv]
// Channel | Direction | Ports                      | Handshake
// request | in        | req_origin_*, req_dir_*    | req_valid / req_stall
// result  | out       | rsp_status, rsp_distance,  | rsp_valid / rsp_stall
//         |           | rsp_hit_x/y/z              |
// config  | in/out    | psel..pwdata, prdata       | APB, pready tied high
//
// One ray enters per cycle while the output is not stalled; the pipeline has products,
// sums and divider setup stages, 31 restoring divider stages, a multiply stage, and the
// add/saturate output register. The quotient bit-per-stage divider sets the depth.
// Synchronous reset clears valid bits and loads the register reset values.
// A stalled output freezes the whole pipeline; nothing is dropped.
module ray_plane_intersect #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rpi_pkg::fix_type        req_origin_x,
   input  rpi_pkg::fix_type        req_origin_y,
   input  rpi_pkg::fix_type        req_origin_z,
   input  rpi_pkg::fix_type        req_dir_x,
   input  rpi_pkg::fix_type        req_dir_y,
   input  rpi_pkg::fix_type        req_dir_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [30:0]             rsp_distance,
   output rpi_pkg::fix_type        rsp_hit_x,
   output rpi_pkg::fix_type        rsp_hit_y,
   output rpi_pkg::fix_type        rsp_hit_z,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [4:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import rpi_pkg::*;

   localparam int XW = MAG_W + FRAC_BITS;

   // configuration
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [31:0] off_ff;
   logic [15:0]        tol_ff;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= 16'sd16384;
         off_ff <= '0;
         tol_ff <= 16'd66;
      end else if (wr_en) begin
         unique case (paddr[4:2])
            REG_NORMAL_X:  nx_ff  <= pwdata[15:0];
            REG_NORMAL_Y:  ny_ff  <= pwdata[15:0];
            REG_NORMAL_Z:  nz_ff  <= pwdata[15:0];
            REG_OFFSET:    off_ff <= pwdata;
            REG_TOLERANCE: tol_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_NORMAL_X:  prdata = 32'(nx_ff);
         REG_NORMAL_Y:  prdata = 32'(ny_ff);
         REG_NORMAL_Z:  prdata = 32'(nz_ff);
         REG_OFFSET:    prdata = off_ff;
         REG_TOLERANCE: prdata = {16'd0, tol_ff};
         default:       prdata = '0;
      endcase
   end

   // pipeline advance
   logic rsp_valid_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // stage 1: products
   logic                     v1_ff;
   fix_type [2:0]            o1_ff, d1_ff;
   logic signed [MAG_W-1:0]  dn1_ff [3];
   logic signed [MAG_W-1:0]  on1_ff [3];
   fix_type [2:0]            o_in, d_in;
   logic signed [MAG_W-1:0]  nv [3];

   assign o_in = {req_origin_z, req_origin_y, req_origin_x};
   assign d_in = {req_dir_z, req_dir_y, req_dir_x};
   assign nv[0] = MAG_W'(nx_ff);
   assign nv[1] = MAG_W'(ny_ff);
   assign nv[2] = MAG_W'(nz_ff);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o1_ff <= o_in;
         d1_ff <= d_in;
         for (int k = 0; k < 3; k++) begin
            dn1_ff[k] <= MAG_W'(d_in[k]) * nv[k];
            on1_ff[k] <= MAG_W'(o_in[k]) * nv[k];
         end
      end
   end

   // stage 2: sums
   logic               v2_ff;
   fix_type [2:0]      o2_ff, d2_ff;
   logic signed [49:0] den2_ff;
   logic signed [50:0] num2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o2_ff   <= o1_ff;
         d2_ff   <= d1_ff;
         den2_ff <= 50'(dn1_ff[0]) + 50'(dn1_ff[1]) + 50'(dn1_ff[2]);
         num2_ff <= -((51'(off_ff) <<< 14) + 51'(on1_ff[0]) + 51'(on1_ff[1])
                      + 51'(on1_ff[2]));
      end
   end

   // stage 3: tests and divider setup
   localparam int NDIV = Q_W;
   div_stage_type div_ff [NDIV+1];
   div_stage_type d3_in;
   logic [49:0]      den_abs;
   logic [50:0]      num_abs;
   logic [XW-1:0]    xfull, r0;

   always_comb begin
      den_abs = den2_ff[49] ? 50'(-den2_ff) : 50'(den2_ff);
      num_abs = num2_ff[50] ? 51'(-num2_ff) : 51'(num2_ff);
      xfull   = XW'(num_abs[MAG_W-1:0]) << FRAC_BITS;
      r0      = xfull >> Q_W;
      d3_in.valid = v2_ff;
      d3_in.dvs   = den_abs[MAG_W-1:0];
      d3_in.org   = o2_ff;
      d3_in.dir   = d2_ff;
      d3_in.quo   = '0;
      d3_in.xlow  = xfull[Q_W-1:0];
      d3_in.ovf   = r0 >= XW'(den_abs[MAG_W-1:0]);
      d3_in.rem   = d3_in.ovf ? '0 : r0[MAG_W-1:0];
      if (den_abs[MAG_W-1:0] < {18'd0, tol_ff, 14'd0})
         d3_in.kind = ST_PARALLEL;
      else if (num2_ff == '0 || (num2_ff[50] != den2_ff[49]))
         d3_in.kind = ST_BEHIND;
      else
         d3_in.kind = ST_HIT;
   end

   always_ff @(posedge clock) begin
      if (reset) div_ff[0].valid <= 1'b0;
      else if (en) div_ff[0].valid <= d3_in.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0].kind <= d3_in.kind;
         div_ff[0].ovf  <= d3_in.ovf;
         div_ff[0].rem  <= d3_in.rem;
         div_ff[0].xlow <= d3_in.xlow;
         div_ff[0].quo  <= d3_in.quo;
         div_ff[0].dvs  <= d3_in.dvs;
         div_ff[0].org  <= d3_in.org;
         div_ff[0].dir  <= d3_in.dir;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar s = 0; s < NDIV; s++) begin : g_div
      div_stage_type st_in;
      logic [MAG_W:0] trial;

      always_comb begin
         st_in = div_ff[s];
         trial = {div_ff[s].rem, div_ff[s].xlow[Q_W-1]};
         st_in.xlow = div_ff[s].xlow << 1;
         if (trial >= {1'b0, div_ff[s].dvs}) begin
            st_in.rem = MAG_W'(trial - {1'b0, div_ff[s].dvs});
            st_in.quo = {div_ff[s].quo[Q_W-2:0], 1'b1};
         end else begin
            st_in.rem = trial[MAG_W-1:0];
            st_in.quo = {div_ff[s].quo[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) div_ff[s+1].valid <= 1'b0;
         else if (en) div_ff[s+1].valid <= st_in.valid;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[s+1].kind <= st_in.kind;
            div_ff[s+1].ovf  <= st_in.ovf;
            div_ff[s+1].rem  <= st_in.rem;
            div_ff[s+1].xlow <= st_in.xlow;
            div_ff[s+1].quo  <= st_in.quo;
            div_ff[s+1].dvs  <= st_in.dvs;
            div_ff[s+1].org  <= st_in.org;
            div_ff[s+1].dir  <= st_in.dir;
         end
      end
   end

   // multiply stage
   logic             vm_ff, hitm_ff, satm_ff;
   status_type       stm_ff, stm_in;
   logic [Q_W-1:0]   qm_ff, q_fin;
   fix_type [2:0]    om_ff, dm_ff;
   logic [62:0]      prod_ff [3];
   logic [31:0]      dmag [3];

   always_comb begin
      q_fin = div_ff[NDIV].ovf ? T_MAX : div_ff[NDIV].quo;
      if (div_ff[NDIV].kind != ST_HIT)
         stm_in = div_ff[NDIV].kind;
      else if (q_fin <= Q_W'(tol_ff))
         stm_in = ST_BEHIND;
      else
         stm_in = ST_HIT;
      for (int k = 0; k < 3; k++)
         dmag[k] = div_ff[NDIV].dir[k][31] ? 32'(-div_ff[NDIV].dir[k])
                                           : 32'(div_ff[NDIV].dir[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else if (en) vm_ff <= div_ff[NDIV].valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stm_ff  <= stm_in;
         hitm_ff <= (stm_in == ST_HIT);
         satm_ff <= div_ff[NDIV].ovf;
         qm_ff   <= q_fin;
         om_ff   <= div_ff[NDIV].org;
         dm_ff   <= div_ff[NDIV].dir;
         for (int k = 0; k < 3; k++)
            prod_ff[k] <= 63'(dmag[k]) * 63'(q_fin);
      end
   end

   // add, saturate, output register
   logic [1:0]         st_out_ff;
   logic [Q_W-1:0]     dist_ff;
   fix_type [2:0]      hit_ff, hit_in;
   logic [2:0]         csat;
   logic signed [63:0] sum [3];
   logic [62:0]        term [3];
   status_type         st_fin;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term[k] = prod_ff[k] >> FRAC_BITS;
         if (dm_ff[k][31])
            sum[k] = 64'(om_ff[k]) - $signed({1'b0, term[k]});
         else
            sum[k] = 64'(om_ff[k]) + $signed({1'b0, term[k]});
         csat[k] = 1'b0;
         if (sum[k] > 64'sd2147483647) begin
            hit_in[k] = 32'h7fff_ffff;
            csat[k]   = 1'b1;
         end else if (sum[k] < -64'sd2147483648) begin
            hit_in[k] = 32'h8000_0000;
            csat[k]   = 1'b1;
         end else begin
            hit_in[k] = sum[k][31:0];
         end
      end
      if (!hitm_ff)
         st_fin = stm_ff;
      else if (satm_ff || (csat != '0))
         st_fin = ST_SAT;
      else
         st_fin = ST_HIT;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= vm_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_out_ff <= st_fin;
         dist_ff   <= hitm_ff ? qm_ff : '0;
         for (int k = 0; k < 3; k++)
            hit_ff[k] <= hitm_ff ? hit_in[k] : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = st_out_ff;
   assign rsp_distance = dist_ff;
   assign rsp_hit_x    = hit_ff[0];
   assign rsp_hit_y    = hit_ff[1];
   assign rsp_hit_z    = hit_ff[2];

endmodule

[sim/ray_plane_intersect_tb.sv]
module ray_plane_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpi_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned LATENCY = 37;
   localparam int unsigned LONG_HOLD = 400;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      fix_type ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct packed {
      status_type    status;
      logic [30:0]   distance;
      fix_type       hx, hy, hz;
   } hit_type;

   class hit_scoreboard;
      logic signed [15:0] nrm_x, nrm_y, nrm_z;
      logic signed [31:0] offset;
      logic [15:0]        tol;
      hit_type            pending[$];
      int unsigned        errors;

      function new();
         nrm_x = 0;
         nrm_y = 0;
         nrm_z = 16384;
         offset = 0;
         tol = 66;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_NORMAL_X:  nrm_x = val[15:0];
            REG_NORMAL_Y:  nrm_y = val[15:0];
            REG_NORMAL_Z:  nrm_z = val[15:0];
            REG_OFFSET:    offset = val;
            REG_TOLERANCE: tol = val[15:0];
            default: ;
         endcase
      endfunction

      function fix_type coord(longint o, longint d, longint q, ref bit sat);
         longint term, v;
         term = ((d < 0 ? -d : d) * q) >>> 16;
         v = d < 0 ? o - term : o + term;
         if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            sat = 1;
         end
         if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            sat = 1;
         end
         return fix_type'(v[31:0]);
      endfunction

      // work out the expected hit of one accepted ray
      function void note_ray(ray_type r);
         longint den, num, aden, anum, q;
         logic [127:0] quot;
         bit sat;
         hit_type h;
         den = longint'(r.dx) * nrm_x + longint'(r.dy) * nrm_y + longint'(r.dz) * nrm_z;
         num = longint'(offset) * 16384 + longint'(r.ox) * nrm_x
               + longint'(r.oy) * nrm_y + longint'(r.oz) * nrm_z;
         num = -num;
         aden = den < 0 ? -den : den;
         anum = num < 0 ? -num : num;
         sat = 0;
         h = '0;
         if (aden < (longint'(tol) << 14)) begin
            h.status = ST_PARALLEL;
         end else if (num == 0 || ((num < 0) != (den < 0))) begin
            h.status = ST_BEHIND;
         end else begin
            // a zero divisor (only with zero tolerance) overflows the quotient
            if (aden == 0)
               quot = '1;
            else
               quot = ({64'd0, anum} << 16) / {64'd0, aden};
            if (quot > 128'h7FFFFFFF) begin
               sat = 1;
               q = 64'h7FFFFFFF;
            end else begin
               q = longint'(quot[63:0]);
            end
            if (q <= longint'(tol)) begin
               h.status = ST_BEHIND;
            end else begin
               h.distance = q[30:0];
               h.hx = coord(r.ox, r.dx, q, sat);
               h.hy = coord(r.oy, r.dy, q, sat);
               h.hz = coord(r.oz, r.dz, q, sat);
               h.status = sat ? ST_SAT : ST_HIT;
            end
         end
         pending = {pending, h};
      endfunction

      function void check_hit(hit_type got);
         hit_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result mismatch expected %p actual %p", want, got);
         end
      endfunction

      function int unsigned outstanding();
         return pending.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   fix_type     req_origin_x, req_origin_y, req_origin_z;
   fix_type     req_dir_x, req_dir_y, req_dir_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [30:0] rsp_distance;
   fix_type     rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   hit_scoreboard sb;
   int unsigned   cycles;
   int unsigned   stall_left;
   bit            hold_req;
   bit            send_calm;
   bit            recv_calm;

   ray_plane_intersect u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z), .req_dir_x(req_dir_x),
      .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_distance(rsp_distance),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y), .rsp_hit_z(rsp_hit_z),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_ray({req_origin_x, req_origin_y, req_origin_z,
                         req_dir_x, req_dir_y, req_dir_z});
         if (rsp_valid && !rsp_stall) begin
            sb.check_hit({status_type'(rsp_status), rsp_distance,
                          rsp_hit_x, rsp_hit_y, rsp_hit_z});
            stall_left = recv_calm ? 0 : $urandom_range(0, 18);
         end
      end
   end

   // receiver: short stalls per result, one long hold-off on request
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_req = 0;
            rsp_stall = 0;
         end else if (stall_left > 0) begin
            rsp_stall = 1;
            stall_left--;
         end else begin
            rsp_stall = 0;
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel = 1;
      pwrite = 1;
      penable = 0;
      paddr = {idx, 2'b00};
      pwdata = val;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_ray(ray_type r);
      int unsigned gap;
      gap = send_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      {req_origin_x, req_origin_y, req_origin_z, req_dir_x, req_dir_y, req_dir_z} = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (LATENCY + 3) @(negedge clock);
   endtask

   function automatic fix_type span(int unsigned half);
      return fix_type'(int'($urandom_range(0, 2 * half)) - int'(half));
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      case ($urandom_range(0, 7))
         0: r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         1: r = {span(1 << 21), span(1 << 21), span(1 << 21),
                 span(300), span(300), span(300)};
         2: r = {span(1 << 30), span(1 << 30), span(1 << 30),
                 span(1 << 30), span(1 << 30), span(1 << 30)};
         default: r = {span(1 << 21), span(1 << 21), span(1 << 21),
                       span(1 << 17), span(1 << 17), span(1 << 17)};
      endcase
      return r;
   endfunction

   task automatic run_phase(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic [31:0] off, logic [15:0] tl, int unsigned count);
      drain();
      csr_write(REG_NORMAL_X, {16'd0, nx});
      csr_write(REG_NORMAL_Y, {16'd0, ny});
      csr_write(REG_NORMAL_Z, {16'd0, nz});
      csr_write(REG_OFFSET, off);
      csr_write(REG_TOLERANCE, {16'd0, tl});
      repeat (count) send_ray(random_ray());
   endtask

   localparam fix_type ONE = 32'sh0001_0000;
   localparam fix_type MAXV = 32'sh7FFF_FFFF;
   localparam fix_type MINV = 32'sh8000_0000;

   initial begin
      sb = new();
      cycles = 0;
      stall_left = 0;
      hold_req = 0;
      send_calm = 0;
      recv_calm = 0;
      reset = 1;
      req_valid = 0;
      {req_origin_x, req_origin_y, req_origin_z, req_dir_x, req_dir_y, req_dir_z} = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(negedge clock);
      reset = 0;

      // reset plane is z = 0, tolerance 66
      send_ray({32'sd0, 32'sd0, -5 * ONE, 32'sd0, 32'sd0, ONE});       // plain hit
      send_ray({ONE, ONE, -5 * ONE, 3 * ONE, -2 * ONE, ONE});          // oblique hit
      send_ray({32'sd0, 32'sd0, -5 * ONE, ONE, ONE, 32'sd0});          // parallel
      send_ray({32'sd0, 32'sd0, -5 * ONE, 32'sd0, 32'sd0, 32'sd65});   // just parallel
      send_ray({32'sd0, 32'sd0, 5 * ONE, 32'sd0, 32'sd0, ONE});        // behind
      send_ray({ONE, ONE, 32'sd0, 32'sd0, 32'sd0, ONE});               // on plane
      send_ray({32'sd0, 32'sd0, -32'sd66, 32'sd0, 32'sd0, ONE});       // t at tolerance
      send_ray({32'sd0, 32'sd0, -32'sd67, 32'sd0, 32'sd0, ONE});       // t just past
      send_ray({32'sd0, 32'sd0, MINV, 32'sd0, 32'sd0, 32'sd66});       // distance saturates
      send_ray({MAXV, MINV, -ONE, MAXV, MINV, 32'sd1000});             // coords saturate
      send_ray({MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
      send_ray({MINV, MINV, MINV, MINV, MINV, MINV});
      send_ray({MINV, MINV, MAXV, MINV, MINV, MINV});
      send_ray({MAXV, MAXV, MINV, MAXV, MAXV, MAXV});
      send_ray({-ONE, -ONE, MAXV, -ONE, -ONE, -ONE});
      send_ray({32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, -32'sd1});        // tiny dir
      send_ray({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
      send_ray({32'sd0, 32'sd0, 32'sd0, -32'sd1, -32'sd1, -32'sd1});
      repeat (160) send_ray(random_ray());

      // writes to an unmapped index leave the plane alone
      drain();
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      repeat (20) send_ray(random_ray());

      run_phase(16'd16384, 16'd0, 16'd0, 32'h0005_0000, 16'd0, 250);
      run_phase(16'd0, -16'sd16384, 16'd0, -32'sh0003_0000, 16'd65535, 200);
      run_phase(16'd9459, 16'd9459, 16'd9459, $urandom, 16'd66, 250);
      recv_calm = 1;
      send_calm = 1;
      run_phase(-16'sd16384, 16'd16384, -16'sd16384, 32'h7FFF_FFFF, 16'd1, 200);
      recv_calm = 0;
      send_calm = 0;
      run_phase(16'h7FFF, 16'h8000, 16'd1, 32'h8000_0000, 16'd0, 200);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                16'($urandom_range(0, 255)), 250);

      // long receiver hold-off with a busy sender: fill up and back-pressure
      run_phase(16'd0, 16'd0, 16'd16384, 32'd0, 16'd66, 0);
      hold_req = 1;
      send_calm = 1;
      repeat (150) send_ray(random_ray());
      send_calm = 0;
      drain();
      repeat (200) send_ray(random_ray());

      drain();
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
